@@ rtl/ukls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ukls_pkg;

   // Operation codes carried in req func
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_WRITE,
      SEQ_TOPRD,
      SEQ_RESP
   } seq_state_type;

   // One stored key/data pair
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] data;
   } pair_type;

   // Input transfer payload
   typedef struct packed {
      logic               func;
      logic signed [31:0] in_key;
      logic signed [31:0] in_data;
   } req_type;

   // Result transfer payload
   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_key;
      logic signed [31:0] out_data;
      logic [4:0]         entry_count;
      logic               is_empty;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/unique_key_lifo_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Steps: a pop reads the popped pair, a pop on empty reads nothing, a push scans the
// stored keys (none when empty), writes the new pair and reads the top; a key match or a
// full stack skips the write. Busy falls as the strobe rises, so the next transfer is
// taken at the edge that ends the strobe cycle. The key check reads one pair per cycle
// through one read port and one 32-bit comparator. Synchronous reset empties the stack
// at once; no clearing pass. The result strobe is one cycle and cannot stall.
module unique_key_lifo_stack #(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire ukls_pkg::req_type req_item,
   output      logic              rsp_valid,
   output      ukls_pkg::rsp_type rsp_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ukls_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               popped_ff, popped_in;
   logic               zero_ff, zero_in;
   ukls_pkg::status_type status_ff, status_in;
   ukls_pkg::req_type  req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ukls_pkg::rsp_type  rsp_ff, rsp_in;

   logic               accept;
   logic               scan_issue;
   logic               key_match;
   logic [CW-1:0]      top_idx;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   ukls_pkg::pair_type wr_pair;
   logic [AW-1:0]      rd_addr;
   ukls_pkg::pair_type rd_pair;

   assign accept     = start && (state_ff == ukls_pkg::SEQ_IDLE);
   assign busy       = (state_ff != ukls_pkg::SEQ_IDLE);
   assign top_idx    = fill_ff - CW'(1);
   assign scan_issue = (scan_idx_ff != fill_ff);
   assign key_match  = cmp_vld_ff && (rd_pair.key == req_ff.in_key);

   ukls_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_pair(wr_pair),
      .rd_addr(rd_addr),
      .rd_pair(rd_pair)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ukls_pkg::SEQ_IDLE: begin
            if (accept) begin
               if (req_item.func == ukls_pkg::FUNC_POP) begin
                  state_in = (fill_ff == '0) ? ukls_pkg::SEQ_RESP : ukls_pkg::SEQ_TOPRD;
               end else begin
                  state_in = (fill_ff == '0) ? ukls_pkg::SEQ_WRITE : ukls_pkg::SEQ_SCAN;
               end
            end
         end
         ukls_pkg::SEQ_SCAN: begin
            if (key_match) begin
               state_in = ukls_pkg::SEQ_TOPRD;
            end else if (!scan_issue) begin
               state_in = (fill_ff == CW'(DEPTH)) ? ukls_pkg::SEQ_TOPRD
                                                  : ukls_pkg::SEQ_WRITE;
            end
         end
         ukls_pkg::SEQ_WRITE: state_in = ukls_pkg::SEQ_TOPRD;
         ukls_pkg::SEQ_TOPRD: state_in = ukls_pkg::SEQ_RESP;
         ukls_pkg::SEQ_RESP:  state_in = ukls_pkg::SEQ_IDLE;
         default:             state_in = ukls_pkg::SEQ_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      fill_in      = fill_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      popped_in    = popped_ff;
      zero_in      = zero_ff;
      status_in    = status_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AW-1:0];
      wr_pair      = '{key: req_ff.in_key, data: req_ff.in_data};
      rd_addr      = top_idx[AW-1:0];
      case (state_ff)
         ukls_pkg::SEQ_IDLE: begin
            if (accept) begin
               req_in      = req_item;
               scan_idx_in = '0;
               popped_in   = 1'b0;
               zero_in     = 1'b0;
               status_in   = ukls_pkg::STAT_OK;
               if (req_item.func == ukls_pkg::FUNC_POP) begin
                  if (fill_ff == '0) begin
                     status_in = ukls_pkg::STAT_UNDERFLOW;
                     zero_in   = 1'b1;
                  end else begin
                     fill_in   = top_idx;
                     popped_in = 1'b1;
                  end
               end
            end
         end
         ukls_pkg::SEQ_SCAN: begin
            // one stored key read per cycle, compared in the cycle after its read
            rd_addr     = scan_idx_ff[AW-1:0];
            cmp_vld_in  = scan_issue && !key_match;
            scan_idx_in = scan_issue ? scan_idx_ff + CW'(1) : scan_idx_ff;
            if (key_match) begin
               status_in = ukls_pkg::STAT_DUPLICATE;
            end else if (!scan_issue && (fill_ff == CW'(DEPTH))) begin
               status_in = ukls_pkg::STAT_OVERFLOW;
            end
         end
         ukls_pkg::SEQ_WRITE: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + CW'(1);
         end
         ukls_pkg::SEQ_TOPRD: begin
            // popped pair sits at the new fill level, otherwise read the top
            rd_addr = popped_ff ? fill_ff[AW-1:0] : top_idx[AW-1:0];
         end
         ukls_pkg::SEQ_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.out_key     = zero_ff ? '0 : rd_pair.key;
            rsp_in.out_data    = zero_ff ? '0 : rd_pair.data;
            rsp_in.entry_count = 5'(fill_ff);
            rsp_in.is_empty    = (fill_ff == '0);
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ukls_pkg::SEQ_IDLE;
         fill_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      popped_ff   <= popped_in;
      zero_ff     <= zero_in;
      status_ff   <= status_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/ukls_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pair storage: one write port, one read port with registered read data
module ukls_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire ukls_pkg::pair_type wr_pair,
   input  wire logic [AW-1:0]     rd_addr,
   output      ukls_pkg::pair_type rd_pair
);

   ukls_pkg::pair_type mem [DEPTH];
   ukls_pkg::pair_type rd_pair_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_pair;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_pair_ff <= mem[rd_addr];
   end

   assign rd_pair = rd_pair_ff;

endmodule

`default_nettype wire

@@ rtl/ukls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ukls_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire ukls_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire ukls_pkg::rsp_type rsp_item
);

   // an accepted transfer keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   // result strobe is a single cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result is issued only once the item is finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while busy");

   // underflow reports an empty stack and a zero pair
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ukls_pkg::STAT_UNDERFLOW)) |->
      (rsp_item.is_empty && (rsp_item.out_key == '0) && (rsp_item.out_data == '0)))
      else $error("underflow result malformed");

endmodule

bind unique_key_lifo_stack ukls_checker u_ukls_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_item (req_item),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);

`default_nettype wire

@@ dv/lifo_result_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result channels of the unique-key LIFO stack,
// keeps its own copy of the stack and checks every result in order.
module lifo_result_checker #(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire ukls_pkg::req_type req_item,
   input  wire logic              rsp_valid,
   input  wire ukls_pkg::rsp_type rsp_item,
   output int                     mismatch_count,
   output int                     pending_count
);

   // Shadow copy of the stack, entry 0 at the bottom
   logic signed [31:0] key_mem [DEPTH];
   logic signed [31:0] data_mem [DEPTH];
   int                 fill_level;

   ukls_pkg::rsp_type expected_results [$];
   int                fail_total;

   // Applies one operation to the shadow stack and returns the result it yields
   function automatic ukls_pkg::rsp_type apply_stack_op(ukls_pkg::req_type op);
      ukls_pkg::rsp_type r;
      logic              key_hit;
      logic              popped;
      r          = '0;
      r.status   = ukls_pkg::STAT_OK;
      key_hit    = 1'b0;
      popped     = 1'b0;
      if (op.func == ukls_pkg::FUNC_PUSH) begin
         for (int i = 0; i < fill_level; i++) begin
            if (key_mem[i] == op.in_key) begin
               key_hit = 1'b1;
            end
         end
         // duplicate check wins over the full check
         if (key_hit) begin
            r.status = ukls_pkg::STAT_DUPLICATE;
         end else if (fill_level >= DEPTH) begin
            r.status = ukls_pkg::STAT_OVERFLOW;
         end else begin
            key_mem[fill_level]  = op.in_key;
            data_mem[fill_level] = op.in_data;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            r.status = ukls_pkg::STAT_UNDERFLOW;
         end else begin
            fill_level--;
            r.out_key  = key_mem[fill_level];
            r.out_data = data_mem[fill_level];
            popped     = 1'b1;
         end
      end
      // everything but a successful pop shows the top pair, or zeros when empty
      if (!popped && fill_level != 0) begin
         r.out_key  = key_mem[fill_level - 1];
         r.out_data = data_mem[fill_level - 1];
      end
      r.entry_count = 5'(fill_level);
      r.is_empty    = (fill_level == 0);
      return r;
   endfunction

   // Result check first, then the new transfer, both on the same edge
   always @(posedge clock) begin
      ukls_pkg::rsp_type want;
      if (reset) begin
         fill_level = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("%0t: result with nothing expected: status %0d key %h data %h",
                           $realtime, rsp_item.status, rsp_item.out_key, rsp_item.out_data);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.status != want.status || rsp_item.out_key != want.out_key ||
                   rsp_item.out_data != want.out_data ||
                   rsp_item.entry_count != want.entry_count ||
                   rsp_item.is_empty != want.is_empty) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: mismatch exp status %0d key %h data %h count %0d empty %0b",
                              $realtime, want.status, want.out_key, want.out_data,
                              want.entry_count, want.is_empty);
                     $display("%0t:          got status %0d key %h data %h count %0d empty %0b",
                              $realtime, rsp_item.status, rsp_item.out_key, rsp_item.out_data,
                              rsp_item.entry_count, rsp_item.is_empty);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_results.push_back(apply_stack_op(req_item));
         end
      end
      mismatch_count <= fail_total;
      pending_count  <= expected_results.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int STACK_DEPTH  = 16;
   localparam int POOL_SIZE    = 24;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 32;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   ukls_pkg::req_type req_item  = '0;
   logic              busy;
   logic              rsp_valid;
   ukls_pkg::rsp_type rsp_item;

   int mismatch_count;
   int pending_count;
   int stall_cycles;

   // Small key pool so random pushes hit stored keys often
   logic signed [31:0] key_pool [POOL_SIZE];

   always #4 clock = ~clock;

   unique_key_lifo_stack #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   lifo_result_checker #(
      .DEPTH(STACK_DEPTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // Watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic ukls_pkg::req_type make_op(logic func, logic signed [31:0] key,
                                                 logic signed [31:0] data);
      ukls_pkg::req_type op;
      op.func    = func;
      op.in_key  = key;
      op.in_data = data;
      return op;
   endfunction

   // Optional gap, then hold start until the transfer happens
   task automatic send_op(ukls_pkg::req_type op, int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= op;
      do @(posedge clock); while (busy);
   endtask

   // Random mix; alternating push-heavy and pop-heavy stretches reach full and empty
   task automatic run_random(int count, int idle_pct);
      int                 push_pct;
      logic signed [31:0] key;
      for (int k = 0; k < count; k++) begin
         push_pct = ((k / 40) % 2 == 0) ? 75 : 30;
         if ($urandom_range(99) < push_pct) begin
            key = ($urandom_range(99) < 40) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : $urandom;
            send_op(make_op(ukls_pkg::FUNC_PUSH, key, $urandom), idle_pct);
         end else begin
            send_op(make_op(ukls_pkg::FUNC_POP, $urandom, $urandom), idle_pct);
         end
      end
   endtask

   initial begin
      logic signed [31:0] key;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = 32'shFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow, push on empty, pop that empties
      send_op(make_op(ukls_pkg::FUNC_POP, 32'sh0, 32'sh0), 0);
      send_op(make_op(ukls_pkg::FUNC_PUSH, 32'sh5A5A_5A5A, 32'shA5A5_A5A5), 0);
      send_op(make_op(ukls_pkg::FUNC_POP, 32'shFFFF_FFFF, 32'shFFFF_FFFF), 0);
      send_op(make_op(ukls_pkg::FUNC_POP, 32'sh0, 32'sh0), 0);

      // Fill to the top with extreme keys and data
      for (int i = 0; i < STACK_DEPTH; i++) begin
         case (i)
            0:       key = 32'sh8000_0000;
            1:       key = 32'sh7FFF_FFFF;
            2:       key = 32'sh0000_0000;
            3:       key = 32'shFFFF_FFFF;
            default: key = i;
         endcase
         send_op(make_op(ukls_pkg::FUNC_PUSH, key, ~key), 0);
      end

      // Full: new key overflows, stored key reports duplicate first
      send_op(make_op(ukls_pkg::FUNC_PUSH, 32'sh1234_5678, 32'sh8000_0000), 0);
      send_op(make_op(ukls_pkg::FUNC_PUSH, 32'shFFFF_FFFF, 32'sh7FFF_FFFF), 0);
      send_op(make_op(ukls_pkg::FUNC_POP, 32'sh0, 32'sh0), 0);

      // Random phases: light sender gaps, heavy sender gaps, none
      run_random(134, 8);
      run_random(133, 77);
      run_random(133, 0);
      start <= 1'b0;

      // Let the last expectation settle before polling it
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ukls_pkg.sv
rtl/ukls_mem.sv
rtl/unique_key_lifo_stack.sv
rtl/ukls_checker.sv
dv/lifo_result_checker.sv
dv/testbench.sv
